FILE: hw/rtl/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants of the scan run segmenter: register indexes,
// reset values, result kinds, the configuration bundle and the queue entry.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int SRS_SCAN_DEPTH  = 1024;
  localparam int SRS_MAX_LEGS    = 4;
  localparam int SRS_QUEUE_DEPTH = 4;

  localparam int SRS_RANGE_W = 16;
  localparam int SRS_SKIP_W  = 9;
  localparam int SRS_SPS_W   = 11;
  localparam int SRS_LEN_W   = 11;
  // widest index and count over the legal parameter ranges
  localparam int SRS_IDX_W   = 12;
  localparam int SRS_CNT_W   = 5;

  localparam int SRS_CFG_IDX_W  = 2;
  localparam int SRS_CFG_DATA_W = 16;

  localparam logic [SRS_LEN_W-1:0] SRS_LEN_MAX = '1;

  localparam logic [SRS_CFG_IDX_W-1:0] REG_MIN_RANGE   = 2'd0;
  localparam logic [SRS_CFG_IDX_W-1:0] REG_MAX_RANGE   = 2'd1;
  localparam logic [SRS_CFG_IDX_W-1:0] REG_SKIP_COUNT  = 2'd2;
  localparam logic [SRS_CFG_IDX_W-1:0] REG_SAMPLES_PER = 2'd3;

  localparam logic [SRS_RANGE_W-1:0] MIN_RANGE_RESET   = 16'd20;
  localparam logic [SRS_RANGE_W-1:0] MAX_RANGE_RESET   = 16'd2000;
  localparam logic [SRS_SKIP_W-1:0]  SKIP_COUNT_RESET  = 9'd40;
  localparam logic [SRS_SPS_W-1:0]   SAMPLES_PER_RESET = 11'd1024;

  localparam logic KIND_RUN     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [SRS_RANGE_W-1:0] min_range_mm;
    logic [SRS_RANGE_W-1:0] max_range_mm;
    logic [SRS_SKIP_W-1:0]  skip_count;
    logic [SRS_SPS_W-1:0]   samples_per_scan;
  } srs_cfg_t;

  typedef struct packed {
    logic                   has_run;
    logic                   has_sum;
    logic [SRS_CNT_W-1:0]   run_num;
    logic [SRS_IDX_W-1:0]   center_idx;
    logic [SRS_RANGE_W-1:0] center_rng;
    logic                   run_ovf;
    logic [SRS_CNT_W-1:0]   sum_count;
    logic                   sum_ovf;
  } srs_entry_t;

endpackage

FILE: hw/rtl/srs_ram.sv
// ----------------------------------------------------------------------------
// srs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module srs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/srs_front.sv
// ----------------------------------------------------------------------------
// srs_front
// Sample intake: stores each sample, gates it against the window and range
// limits, tracks the open run and issues the centre read. One stage later
// the finished queue entry is pushed towards the output side.
// ----------------------------------------------------------------------------
module srs_front
  import srs_pkg::*;
#(
  parameter int SCAN_DEPTH = SRS_SCAN_DEPTH,
  parameter int MAX_LEGS   = SRS_MAX_LEGS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  srs_cfg_t                              cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [SRS_RANGE_W-1:0]                range_mm,
  input  logic                                  sample_last,
  input  logic [$clog2(SRS_QUEUE_DEPTH+1)-1:0]  queue_count,
  output logic                                  push_valid,
  output srs_entry_t                            push_entry
);

  localparam int AW   = $clog2(SCAN_DEPTH);
  localparam int CNTW = $clog2(MAX_LEGS + 1);
  localparam int CW   = ((AW > SRS_SPS_W) ? AW : SRS_SPS_W) + 1;
  localparam int SW   = ((AW > SRS_LEN_W - 1) ? AW : SRS_LEN_W - 1) + 1;
  localparam int QCW  = $clog2(SRS_QUEUE_DEPTH + 1);
  localparam logic [AW-1:0]   LAST_POS  = AW'(SCAN_DEPTH - 1);
  localparam logic [CNTW-1:0] LEG_LIMIT = CNTW'(MAX_LEGS);

  logic [AW-1:0]        pos;
  logic                 run_active;
  logic [AW-1:0]        run_start;
  logic [SRS_LEN_W-1:0] run_length;
  logic [CNTW-1:0]      run_count;
  logic                 overflow_seen;

  logic                   s1_valid;
  srs_entry_t             s1_entry;
  logic                   s1_bypass;
  logic [SRS_RANGE_W-1:0] s1_bypass_data;
  logic [SRS_RANGE_W-1:0] ram_rdata;

  logic                 accept;
  logic                 in_window;
  logic                 gated;
  logic [AW-1:0]        eff_start;
  logic [SRS_LEN_W-1:0] eff_len;
  logic                 close_run;
  logic                 report;
  logic                 drop;
  logic [SW-1:0]        center_sum;
  logic [AW-1:0]        center;
  logic [CNTW-1:0]      count_after;
  logic                 ovf_after;

  assign in_ready = ((QCW+1)'(queue_count) + (QCW+1)'(s1_valid)) <
                    (QCW+1)'(SRS_QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  always_comb begin
    in_window = (CW'(pos) >= CW'(cfg.skip_count)) &&
                ((CW'(pos) + CW'(cfg.skip_count)) < CW'(cfg.samples_per_scan));
    gated     = in_window && (range_mm > cfg.min_range_mm) &&
                (range_mm < cfg.max_range_mm);

    eff_start = (gated && !run_active) ? pos : run_start;
    if (!gated) begin
      eff_len = run_length;
    end else if (!run_active) begin
      eff_len = SRS_LEN_W'(1);
    end else if (run_length == SRS_LEN_MAX) begin
      eff_len = run_length;
    end else begin
      eff_len = run_length + SRS_LEN_W'(1);
    end

    // a gated sample closes the run only at scan end
    close_run = gated ? sample_last : run_active;
    report    = close_run && (run_count < LEG_LIMIT);
    drop      = close_run && !report;

    center_sum = SW'(eff_start) + SW'(eff_len[SRS_LEN_W-1:1]);
    center     = (center_sum > SW'(SCAN_DEPTH - 1)) ? LAST_POS : center_sum[AW-1:0];

    count_after = run_count + CNTW'(report);
    ovf_after   = overflow_seen || drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      run_active    <= 1'b0;
      run_start     <= '0;
      run_length    <= '0;
      run_count     <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (sample_last) begin
        pos           <= '0;
        run_active    <= 1'b0;
        run_start     <= '0;
        run_length    <= '0;
        run_count     <= '0;
        overflow_seen <= 1'b0;
      end else begin
        pos           <= (pos == LAST_POS) ? pos : pos + AW'(1);
        run_active    <= gated;
        run_start     <= eff_start;
        run_length    <= eff_len;
        run_count     <= count_after;
        overflow_seen <= ovf_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (report || sample_last);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_entry.has_run    <= report;
      s1_entry.has_sum    <= sample_last;
      s1_entry.run_num    <= SRS_CNT_W'(run_count);
      s1_entry.center_idx <= SRS_IDX_W'(center);
      s1_entry.center_rng <= '0;
      s1_entry.run_ovf    <= overflow_seen;
      s1_entry.sum_count  <= SRS_CNT_W'(count_after);
      s1_entry.sum_ovf    <= ovf_after;
      // centre on the sample being written this cycle
      s1_bypass           <= (center == pos);
      s1_bypass_data      <= range_mm;
    end
  end

  srs_ram #(
    .WIDTH (SRS_RANGE_W),
    .DEPTH (SCAN_DEPTH)
  ) u_scan_store (
    .clk   (clk),
    .we    (accept),
    .waddr (pos),
    .wdata (range_mm),
    .re    (accept && report),
    .raddr (center),
    .rdata (ram_rdata)
  );

  always_comb begin
    push_entry            = s1_entry;
    push_entry.center_rng = s1_bypass ? s1_bypass_data : ram_rdata;
  end

  assign push_valid = s1_valid;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    run_count <= LEG_LIMIT)
    else $error("run count beyond leg limit");

  a_scan_restart: assert property (@(posedge clk) disable iff (rst)
    accept && sample_last |=> pos == '0 && run_count == '0 && !run_active)
    else $error("scan state not cleared after last sample");
`endif

endmodule

FILE: hw/rtl/srs_fifo.sv
// ----------------------------------------------------------------------------
// srs_fifo
// Short queue of result entries between the intake and the output side.
// ----------------------------------------------------------------------------
module srs_fifo
  import srs_pkg::*;
(
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  srs_entry_t                           push_entry,
  input  logic                                 pop,
  output srs_entry_t                           pop_entry,
  output logic                                 empty,
  output logic [$clog2(SRS_QUEUE_DEPTH+1)-1:0] count
);

  localparam int PW  = $clog2(SRS_QUEUE_DEPTH);
  localparam int QCW = $clog2(SRS_QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(SRS_QUEUE_DEPTH - 1);

  srs_entry_t    slots [SRS_QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign pop_entry = slots[rd_ptr];
  assign empty     = (count == '0);

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> count < QCW'(SRS_QUEUE_DEPTH))
    else $error("queue overrun");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue underrun");
`endif

endmodule

FILE: hw/rtl/srs_back.sv
// ----------------------------------------------------------------------------
// srs_back
// Output side: takes queue entries and presents run reports and scan
// summaries one transaction at a time from an output register.
// ----------------------------------------------------------------------------
module srs_back
  import srs_pkg::*;
#(
  parameter int SCAN_DEPTH = SRS_SCAN_DEPTH,
  parameter int MAX_LEGS   = SRS_MAX_LEGS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  srs_entry_t                       entry,
  input  logic                             empty,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             result_kind,
  output logic [$clog2(MAX_LEGS+1)-1:0]    run_number,
  output logic [$clog2(SCAN_DEPTH)-1:0]    center_index,
  output logic [SRS_RANGE_W-1:0]           center_range_mm,
  output logic [$clog2(MAX_LEGS+1)-1:0]    runs_found,
  output logic                             overflow_flag,
  output logic                             result_last
);

  localparam int AW   = $clog2(SCAN_DEPTH);
  localparam int CNTW = $clog2(MAX_LEGS + 1);

  logic            pend_sum;
  logic [CNTW-1:0] pend_count;
  logic            pend_ovf;
  logic            slot_free;

  assign slot_free = !out_valid || out_ready;
  assign pop       = slot_free && !pend_sum && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_sum  <= 1'b0;
    end else if (slot_free) begin
      if (pend_sum) begin
        out_valid <= 1'b1;
        pend_sum  <= 1'b0;
      end else if (!empty) begin
        out_valid <= 1'b1;
        pend_sum  <= entry.has_run && entry.has_sum;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_sum || !entry.has_run) begin
        result_kind     <= KIND_SUMMARY;
        run_number      <= '0;
        center_index    <= '0;
        center_range_mm <= '0;
        runs_found      <= pend_sum ? pend_count : entry.sum_count[CNTW-1:0];
        overflow_flag   <= pend_sum ? pend_ovf : entry.sum_ovf;
        result_last     <= 1'b1;
      end else begin
        result_kind     <= KIND_RUN;
        run_number      <= entry.run_num[CNTW-1:0];
        center_index    <= entry.center_idx[AW-1:0];
        center_range_mm <= entry.center_rng;
        runs_found      <= entry.run_num[CNTW-1:0] + CNTW'(1);
        overflow_flag   <= entry.run_ovf;
        result_last     <= 1'b0;
      end
    end
    if (pop) begin
      pend_count <= entry.sum_count[CNTW-1:0];
      pend_ovf   <= entry.sum_ovf;
    end
  end

`ifndef NO_ASSERTIONS
  a_pend_behind_run: assert property (@(posedge clk) disable iff (rst)
    pend_sum |-> out_valid && result_kind == KIND_RUN)
    else $error("held summary without a run report in front of it");
`endif

endmodule

FILE: hw/rtl/scan_run_segmenter_unit.sv
// ----------------------------------------------------------------------------
// scan_run_segmenter_unit
// Range-gated run clustering over one lidar scan, reporting run centres and
// an end-of-scan summary.
// ----------------------------------------------------------------------------
// One sample is accepted every clock cycle while the queue has room. Each
// sample is written to the scan memory; the centre read for a closing run
// is issued in the same cycle on the memory's read port, and its result
// passes the intake stage register and the queue on its way to the output
// register. A four-entry queue separates intake from output: intake keeps
// running while results wait, and stalls only once the queue, counting the
// entry still on its way in, is full. A sample that closes a run on the last
// sample of a scan yields two transactions. The scan memory is not cleared
// after reset and needs no start-up pass.
module scan_run_segmenter_unit
  import srs_pkg::*;
#(
  parameter int SCAN_DEPTH = SRS_SCAN_DEPTH,
  parameter int MAX_LEGS   = SRS_MAX_LEGS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [SRS_CFG_IDX_W-1:0]      cfg_index,
  input  logic [SRS_CFG_DATA_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SRS_RANGE_W-1:0]        range_mm,
  input  logic                          sample_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [$clog2(MAX_LEGS+1)-1:0] run_number,
  output logic [$clog2(SCAN_DEPTH)-1:0] center_index,
  output logic [SRS_RANGE_W-1:0]        center_range_mm,
  output logic [$clog2(MAX_LEGS+1)-1:0] runs_found,
  output logic                          overflow_flag,
  output logic                          result_last
);

  srs_cfg_t   cfg;
  logic       push_valid;
  srs_entry_t push_entry;
  srs_entry_t pop_entry;
  logic       pop;
  logic       empty;
  logic [$clog2(SRS_QUEUE_DEPTH+1)-1:0] queue_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_range_mm     <= MIN_RANGE_RESET;
      cfg.max_range_mm     <= MAX_RANGE_RESET;
      cfg.skip_count       <= SKIP_COUNT_RESET;
      cfg.samples_per_scan <= SAMPLES_PER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_RANGE:   cfg.min_range_mm     <= cfg_data;
        REG_MAX_RANGE:   cfg.max_range_mm     <= cfg_data;
        REG_SKIP_COUNT:  cfg.skip_count       <= cfg_data[SRS_SKIP_W-1:0];
        REG_SAMPLES_PER: cfg.samples_per_scan <= cfg_data[SRS_SPS_W-1:0];
        default: ;
      endcase
    end
  end

  srs_front #(
    .SCAN_DEPTH (SCAN_DEPTH),
    .MAX_LEGS   (MAX_LEGS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .range_mm    (range_mm),
    .sample_last (sample_last),
    .queue_count (queue_count),
    .push_valid  (push_valid),
    .push_entry  (push_entry)
  );

  srs_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (empty),
    .count      (queue_count)
  );

  srs_back #(
    .SCAN_DEPTH (SCAN_DEPTH),
    .MAX_LEGS   (MAX_LEGS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .entry           (pop_entry),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_kind     (result_kind),
    .run_number      (run_number),
    .center_index    (center_index),
    .center_range_mm (center_range_mm),
    .runs_found      (runs_found),
    .overflow_flag   (overflow_flag),
    .result_last     (result_last)
  );

endmodule
